[sv/frs_pkg.sv]
`default_nettype none
package frs_pkg;

  localparam int KEY_RANGE = 1024;
  localparam int KEY_W     = $clog2(KEY_RANGE);
  localparam int TDATA_W   = ((KEY_W + 7) / 8) * 8;
  // The ring wraps by truncation, so the depth stays a power of two.
  localparam int DEPTH     = 64;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CAP_W     = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);
  localparam int APB_DW    = 32;
  localparam int PADDR_W   = 3;
  localparam logic [PADDR_W-3:0] REG_CAPACITY = '0;
  localparam logic MODE_ACCESS = 1'b0;
  localparam logic MODE_DRAIN  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic sweep;
    logic emit_hit;
    logic emit_miss;
    logic mark;
    logic emit_drain;
    logic emit_empty;
  } frs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic present;
    logic full;
    logic none_held;
    logic one_held;
    logic out_free;
    logic sweep_done;
  } frs_status_t;

endpackage
`default_nettype wire

[sv/fifo_replacement_set_core.sv]
// Access: a hit is loaded into the output register from the lookup step once the output is free,
// a miss likewise, followed by a separate step that marks the new key.
// Drain: the capture reads the oldest key, then one result per cycle.
// The single-port presence map and key ring set these steps; a stalled output holds the walk.
// Reset is synchronous; afterwards a sweep over every key clears the presence map, and
// s_tready stays low until it ends. Capacity resets to 64 and may be written at any time.
`default_nettype none
module fifo_replacement_set_core import frs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  // Input stream.
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [TDATA_W-1:0] s_tdata,   // key, then zero padding
  input  wire logic               s_tuser,   // mode
  // Result stream.
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [TDATA_W-1:0]      m_tdata,   // out_key, then zero padding
  output logic [2:0]              m_tuser,   // hit, evicted, empty_res
  output logic                    m_tlast,
  // Configuration port.
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready
);

  frs_cmd_t         cmd;
  frs_status_t      status;
  logic [CAP_W-1:0] capacity;
  logic             cfg_write;
  logic             out_hit;
  logic             out_evicted;
  logic             out_empty;
  logic [KEY_W-1:0] out_key;

  // The register file holds only the capacity register, which the datapath reads directly.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_write && paddr[PADDR_W-1:2] == REG_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == REG_CAPACITY) begin
      prdata = APB_DW'(capacity);
    end
  end

  // The controller sequences each item; the datapath owns both memories and the
  // output register, so a finished result waits there and the walk stalls until it is taken.
  frs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_mode  (s_tuser),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  frs_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_key      (s_tdata[KEY_W-1:0]),
    .capacity    (capacity),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_hit     (out_hit),
    .out_evicted (out_evicted),
    .out_key     (out_key),
    .out_last    (m_tlast),
    .out_empty   (out_empty)
  );

  assign m_tdata = TDATA_W'(out_key);
  assign m_tuser = {out_empty, out_evicted, out_hit};

endmodule
`default_nettype wire

[sv/frs_ctrl.sv]
`default_nettype none
module frs_ctrl import frs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire logic  in_mode,
  output logic       in_ready,
  input  frs_status_t status,
  output frs_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_MARK,
    S_DRAIN
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (status.sweep_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = (in_mode == MODE_DRAIN) ? S_DRAIN : S_LOOK;
        end
      end
      S_LOOK: begin
        if (status.out_free) begin
          if (status.present) begin
            cmd.emit_hit = 1'b1;
            state_next   = S_IDLE;
          end else begin
            cmd.emit_miss = 1'b1;
            state_next    = S_MARK;
          end
        end
      end
      S_MARK: begin
        cmd.mark   = 1'b1;
        state_next = S_IDLE;
      end
      S_DRAIN: begin
        if (status.out_free) begin
          if (status.none_held) begin
            cmd.emit_empty = 1'b1;
            state_next     = S_IDLE;
          end else begin
            cmd.emit_drain = 1'b1;
            if (status.one_held) begin
              state_next = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

[sv/frs_datapath.sv]
`default_nettype none
module frs_datapath import frs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  frs_cmd_t              cmd,
  output frs_status_t           status,
  input  wire logic [KEY_W-1:0] in_key,
  input  wire logic [CAP_W-1:0] capacity,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_hit,
  output logic                  out_evicted,
  output logic [KEY_W-1:0]      out_key,
  output logic                  out_last,
  output logic                  out_empty
);

  logic             map_mem [KEY_RANGE];
  logic [KEY_W-1:0] ring_mem [DEPTH];

  logic [KEY_W-1:0] key_q;
  logic             map_q;
  logic [KEY_W-1:0] ring_q;
  logic [PTR_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic [KEY_W-1:0] sweep_cnt;

  logic [CNT_W-1:0] limit;
  logic             full;
  logic             one_held;
  logic             evict;
  logic             emit_any;
  logic [PTR_W-1:0] tail;
  logic             map_we;
  logic [KEY_W-1:0] map_waddr;
  logic             map_wdata;
  logic             ring_re;
  logic [PTR_W-1:0] ring_raddr;

  // A capacity of zero acts as one; anything above the ring depth saturates.
  always_comb begin
    if (capacity == '0) begin
      limit = CNT_W'(1);
    end else if (capacity > CAP_W'(DEPTH)) begin
      limit = CNT_W'(DEPTH);
    end else begin
      limit = CNT_W'(capacity);
    end
  end

  assign full     = (count >= limit);
  assign one_held = (count == CNT_W'(1));
  assign evict    = cmd.emit_miss && full;
  assign emit_any = cmd.emit_hit | cmd.emit_miss | cmd.emit_drain | cmd.emit_empty;
  // With or without an eviction the new key lands at head + count.
  assign tail     = head + count[PTR_W-1:0];

  assign status.present    = map_q;
  assign status.full       = full;
  assign status.none_held  = (count == '0);
  assign status.one_held   = one_held;
  assign status.out_free   = !out_valid || out_ready;
  assign status.sweep_done = (sweep_cnt == '1);

  always_comb begin
    map_we    = 1'b1;
    map_waddr = ring_q;
    map_wdata = 1'b0;
    if (cmd.sweep) begin
      map_waddr = sweep_cnt;
    end else if (evict || cmd.emit_drain) begin
      map_waddr = ring_q;
    end else if (cmd.mark) begin
      map_waddr = key_q;
      map_wdata = 1'b1;
    end else begin
      map_we = 1'b0;
    end
  end

  assign ring_re    = cmd.capture || (cmd.emit_drain && !one_held);
  assign ring_raddr = cmd.capture ? head : head + PTR_W'(1);

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (cmd.capture) begin
      map_q <= map_mem[in_key];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_miss) begin
      ring_mem[tail] <= key_q;
    end
    if (ring_re) begin
      ring_q <= ring_mem[ring_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      sweep_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.sweep) begin
        sweep_cnt <= sweep_cnt + KEY_W'(1);
      end
      if (cmd.emit_miss) begin
        if (full) begin
          head <= head + PTR_W'(1);
        end else begin
          count <= count + CNT_W'(1);
        end
      end
      if (cmd.emit_drain) begin
        if (one_held) begin
          head  <= '0;
          count <= '0;
        end else begin
          head  <= head + PTR_W'(1);
          count <= count - CNT_W'(1);
        end
      end
      if (cmd.emit_empty) begin
        head <= '0;
      end
      if (emit_any) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_q <= in_key;
    end
    if (emit_any) begin
      out_hit     <= cmd.emit_hit;
      out_evicted <= evict;
      out_key     <= (evict || cmd.emit_drain) ? ring_q : '0;
      out_last    <= cmd.emit_drain ? one_held : 1'b1;
      out_empty   <= cmd.emit_empty;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("held count exceeds ring depth");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit_any |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_drain && one_held) |=> (count == '0 && head == '0))
    else $error("final drain transfer did not empty the set");

  a_append: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_miss && !full) |=> (count == $past(count) + CNT_W'(1)))
    else $error("append without eviction did not grow the set");

endmodule
`default_nettype wire
